// File: hdl/tobf_pkg.sv
// Shared types, constants and helpers for the TDoA outlier bucket filter.
// Used by tobf_ctrl, tobf_dp and tdoa_outlier_bucket_filter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tobf_pkg;

    localparam int NUM_LEVELS = 7;
    localparam int LEVEL_W    = 23;
    localparam int CLOSE_W    = 8;
    localparam int LVL_IDX_W  = 3;
    localparam int BKT_W      = 4;
    localparam int CFG_IDX_W  = 3;

    localparam int IN_TDATA_W  = 352;   // eleven 32-bit fields
    localparam int OUT_TDATA_W = 8;

    localparam logic [BKT_W-1:0] BUCKET_MAX       = 4'd10;
    localparam logic [BKT_W-1:0] BUCKET_THRESHOLD = 4'd2;

    localparam logic [LVL_IDX_W-1:0] LEVEL_OPEN = 3'd7;
    localparam logic [LVL_IDX_W-1:0] LAST_LEVEL = 3'(NUM_LEVELS - 1);

    // configuration register indexes beyond the level table
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLOSE = 3'd7;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET [NUM_LEVELS] = '{
        23'd26214, 23'd52429, 23'd78643, 23'd104858,
        23'd131072, 23'd196608, 23'd262144
    };
    localparam logic [CLOSE_W-1:0] CLOSE_DELAY_RESET = 8'd30;

    // multiplier operand selects; the accumulate action follows the select
    localparam int MSEL_W = 4;
    localparam logic [MSEL_W-1:0] MS_TD  = 4'd0;
    localparam logic [MSEL_W-1:0] MS_DX  = 4'd1;
    localparam logic [MSEL_W-1:0] MS_DY  = 4'd2;
    localparam logic [MSEL_W-1:0] MS_DZ  = 4'd3;
    localparam logic [MSEL_W-1:0] MS_ERR = 4'd4;
    localparam logic [MSEL_W-1:0] MS_GX  = 4'd5;
    localparam logic [MSEL_W-1:0] MS_GY  = 4'd6;
    localparam logic [MSEL_W-1:0] MS_GZ  = 4'd7;
    localparam logic [MSEL_W-1:0] MS_LVL = 4'd8;
    localparam logic [MSEL_W-1:0] MS_P00 = 4'd9;
    localparam logic [MSEL_W-1:0] MS_P01 = 4'd10;
    localparam logic [MSEL_W-1:0] MS_P10 = 4'd11;
    localparam logic [MSEL_W-1:0] MS_P11 = 4'd12;

    typedef struct packed {
        logic        mode;
        logic [31:0] range_diff;
        logic [31:0] anchor_a_x;
        logic [31:0] anchor_a_y;
        logic [31:0] anchor_a_z;
        logic [31:0] anchor_b_x;
        logic [31:0] anchor_b_y;
        logic [31:0] anchor_b_z;
        logic [31:0] innovation;
        logic [31:0] grad_x;
        logic [31:0] grad_y;
        logic [31:0] grad_z;
    } t_item;

    typedef struct packed {
        logic                 load;
        logic                 mul_en;
        logic [MSEL_W-1:0]    mul_sel;
        logic [LVL_IDX_W-1:0] lvl;
        logic                 upd_bucket;
        logic                 decide;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic geo_ok;
    } t_stat;

    typedef struct packed {
        logic                 accepted;
        logic [LVL_IDX_W-1:0] active_level;
    } t_res;

    // magnitude of a signed 32-bit value; -2^31 maps to 2^31
    function automatic logic [31:0] f_mag(input logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return m;
    endfunction

    // magnitude of the difference of two signed 32-bit values, at most 2^32-1
    function automatic logic [31:0] f_mag_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? (~d + 33'd1) : d;
        return m[31:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/tdoa_outlier_bucket_filter.sv
// Top level of the TDoA outlier bucket filter: stream ports, output register,
// controller and datapath. Depends on tobf_pkg, tobf_ctrl, tobf_dp.
//
//  channel  | dir | width | content
//  ---------+-----+-------+---------------------------------------------------
//  s_axis   | in  | 352+1 | one TDoA sample; tuser = mode
//  m_axis   | out | 8     | verdict: accepted, active_level
//  cfg      | in  | 3+23  | level_0..level_6 at index 0..6, close_delay at 7
//
//  One sample at a time through a single shared 32x32 multiplier.
//  Simple mode or failed geometric check: eight squarings, then the result;
//  the next sample is taken once the result is handed to the output register.
//  Stepped mode: eight squarings, then a slot per level for seven levels
//  (level^2 and four partial products each), then the result.
//  A finished result waits in the output register; a stalled m_axis holds the
//  next result in the controller until the register frees. Synchronous reset.
`timescale 1ns / 1ps
`default_nettype none

module tdoa_outlier_bucket_filter (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] range_diff, [63:32] anchor_a_x, [95:64] anchor_a_y,
    // [127:96] anchor_a_z, [159:128] anchor_b_x, [191:160] anchor_b_y,
    // [223:192] anchor_b_z, [255:224] innovation, [287:256] grad_x,
    // [319:288] grad_y, [351:320] grad_z
    input  wire logic [tobf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] accepted, [3:1] active_level, [7:4] zero
    output logic [tobf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                i_cfg_wen,
    input  wire logic [tobf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tobf_pkg::LEVEL_W-1:0]        i_cfg_wdata
);

    tobf_pkg::t_item w_item;
    tobf_pkg::t_cmd  w_cmd;
    tobf_pkg::t_stat w_stat;
    tobf_pkg::t_res  w_res;
    logic            w_out_free;

    logic                             r_out_valid;
    logic [tobf_pkg::OUT_TDATA_W-1:0] r_out_data;

    assign w_item.mode       = s_axis_tuser;
    assign w_item.range_diff = s_axis_tdata[31:0];
    assign w_item.anchor_a_x = s_axis_tdata[63:32];
    assign w_item.anchor_a_y = s_axis_tdata[95:64];
    assign w_item.anchor_a_z = s_axis_tdata[127:96];
    assign w_item.anchor_b_x = s_axis_tdata[159:128];
    assign w_item.anchor_b_y = s_axis_tdata[191:160];
    assign w_item.anchor_b_z = s_axis_tdata[223:192];
    assign w_item.innovation = s_axis_tdata[255:224];
    assign w_item.grad_x     = s_axis_tdata[287:256];
    assign w_item.grad_y     = s_axis_tdata[319:288];
    assign w_item.grad_z     = s_axis_tdata[351:320];

    assign w_out_free = !r_out_valid || m_axis_tready;

    tobf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd)
    );

    tobf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (w_item),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (w_stat),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.decide) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.decide) begin
            r_out_data <= {4'b0000, w_res.active_level, w_res.accepted};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // one sample in flight: no second transfer right after a first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a sample is in progress");

    a_decide_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.decide |-> w_out_free)
        else $error("result issued while output register is occupied");

    a_decide_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.decide |=> m_axis_tvalid)
        else $error("issued result not presented");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.mul_en, w_cmd.upd_bucket, w_cmd.decide}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: hdl/tobf_ctrl.sv
// Sequencer for the TDoA outlier filter: input handshake, multiplier schedule,
// level sweep and result hand-off. Depends on tobf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tobf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tobf_pkg::t_stat i_stat,
    input  wire logic           i_out_free,
    output tobf_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SQW  = 3'd2;
    localparam logic [2:0] S_LVL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [tobf_pkg::LVL_IDX_W-1:0] r_lvl, n_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lvl   <= n_lvl;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_lvl      = r_lvl;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.lvl  = r_lvl;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQ;
                    n_cnt      = 3'd0;
                end
            end
            S_SQ: begin
                // one squaring per cycle: range, anchor deltas, error, gradient
                o_cmd.mul_en = 1'b1;
                case (r_cnt)
                    3'd0:    o_cmd.mul_sel = tobf_pkg::MS_TD;
                    3'd1:    o_cmd.mul_sel = tobf_pkg::MS_DX;
                    3'd2:    o_cmd.mul_sel = tobf_pkg::MS_DY;
                    3'd3:    o_cmd.mul_sel = tobf_pkg::MS_DZ;
                    3'd4:    o_cmd.mul_sel = tobf_pkg::MS_ERR;
                    3'd5:    o_cmd.mul_sel = tobf_pkg::MS_GX;
                    3'd6:    o_cmd.mul_sel = tobf_pkg::MS_GY;
                    3'd7:    o_cmd.mul_sel = tobf_pkg::MS_GZ;
                    default: o_cmd.mul_sel = tobf_pkg::MS_TD;
                endcase
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = S_SQW;
                    n_cnt   = 3'd0;
                end
            end
            S_SQW: begin
                n_lvl   = '0;
                n_cnt   = 3'd0;
                n_state = (i_stat.mode && i_stat.geo_ok) ? S_LVL : S_DONE;
            end
            S_LVL: begin
                // slot per level: level^2, bubble, four partial products,
                // drain, compare and bucket update
                case (r_cnt)
                    3'd0: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = tobf_pkg::MS_LVL;
                    end
                    3'd2: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = tobf_pkg::MS_P00;
                    end
                    3'd3: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = tobf_pkg::MS_P01;
                    end
                    3'd4: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = tobf_pkg::MS_P10;
                    end
                    3'd5: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = tobf_pkg::MS_P11;
                    end
                    3'd7: begin
                        o_cmd.upd_bucket = 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_cnt = 3'd0;
                    if (r_lvl == tobf_pkg::LAST_LEVEL) begin
                        n_state = S_DONE;
                    end else begin
                        n_lvl = r_lvl + 3'd1;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/tobf_dp.sv
// Datapath of the TDoA outlier filter: captured magnitudes, shared 32x32
// multiplier with accumulators, level registers, buckets and hold-off.
// Depends on tobf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tobf_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire tobf_pkg::t_cmd                     i_cmd,
    input  wire tobf_pkg::t_item                    i_item,
    input  wire logic                               i_cfg_wen,
    input  wire logic [tobf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tobf_pkg::LEVEL_W-1:0]       i_cfg_wdata,
    output tobf_pkg::t_stat                         o_stat,
    output tobf_pkg::t_res                          o_res
);

    // configuration
    logic [tobf_pkg::LEVEL_W-1:0] r_level [tobf_pkg::NUM_LEVELS];
    logic [tobf_pkg::CLOSE_W-1:0] r_close;

    // captured item
    logic        r_mode;
    logic [31:0] r_mag_td, r_mag_dx, r_mag_dy, r_mag_dz;
    logic [31:0] r_mag_err, r_mag_gx, r_mag_gy, r_mag_gz;

    // multiplier and accumulators
    logic [31:0]                 w_a, w_b;
    logic [63:0]                 w_prod;
    logic [63:0]                 r_prod;
    logic                        r_pv;
    logic [tobf_pkg::MSEL_W-1:0] r_psel;
    logic [62:0]                 r_td2;
    logic [65:0]                 r_geo_sum;
    logic [62:0]                 r_err2;
    logic [63:0]                 r_g2;
    logic [45:0]                 r_lv2;
    logic [109:0]                r_acc;

    // filter state
    logic [tobf_pkg::BKT_W-1:0]     r_bucket [tobf_pkg::NUM_LEVELS];
    logic [tobf_pkg::NUM_LEVELS-1:0] r_within;
    logic [tobf_pkg::LVL_IDX_W-1:0] r_prior;
    logic [tobf_pkg::CLOSE_W-1:0]   r_hold, n_hold;

    logic [tobf_pkg::LEVEL_W-1:0]   w_level;
    logic                           w_geo_ok;
    logic                           w_within;
    logic [tobf_pkg::BKT_W-1:0]     w_bkt_cur, n_bkt;
    logic [tobf_pkg::LVL_IDX_W-1:0] w_idx, w_sel;
    logic [7:0]                     w_within8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tobf_pkg::NUM_LEVELS; i++) begin
                r_level[i] <= tobf_pkg::LEVEL_RESET[i];
            end
            r_close <= tobf_pkg::CLOSE_DELAY_RESET;
        end else if (i_cfg_wen) begin
            for (int i = 0; i < tobf_pkg::NUM_LEVELS; i++) begin
                if (i_cfg_idx == tobf_pkg::CFG_IDX_W'(i)) begin
                    r_level[i] <= i_cfg_wdata;
                end
            end
            if (i_cfg_idx == tobf_pkg::CFG_IDX_CLOSE) begin
                r_close <= i_cfg_wdata[tobf_pkg::CLOSE_W-1:0];
            end
        end
    end

    assign w_level = r_level[i_cmd.lvl];

    always_comb begin
        w_a = 32'd0;
        w_b = 32'd0;
        case (i_cmd.mul_sel)
            tobf_pkg::MS_TD: begin
                w_a = r_mag_td;
                w_b = r_mag_td;
            end
            tobf_pkg::MS_DX: begin
                w_a = r_mag_dx;
                w_b = r_mag_dx;
            end
            tobf_pkg::MS_DY: begin
                w_a = r_mag_dy;
                w_b = r_mag_dy;
            end
            tobf_pkg::MS_DZ: begin
                w_a = r_mag_dz;
                w_b = r_mag_dz;
            end
            tobf_pkg::MS_ERR: begin
                w_a = r_mag_err;
                w_b = r_mag_err;
            end
            tobf_pkg::MS_GX: begin
                w_a = r_mag_gx;
                w_b = r_mag_gx;
            end
            tobf_pkg::MS_GY: begin
                w_a = r_mag_gy;
                w_b = r_mag_gy;
            end
            tobf_pkg::MS_GZ: begin
                w_a = r_mag_gz;
                w_b = r_mag_gz;
            end
            tobf_pkg::MS_LVL: begin
                w_a = 32'(w_level);
                w_b = 32'(w_level);
            end
            tobf_pkg::MS_P00: begin
                w_a = r_lv2[31:0];
                w_b = r_g2[31:0];
            end
            tobf_pkg::MS_P01: begin
                w_a = r_lv2[31:0];
                w_b = r_g2[63:32];
            end
            tobf_pkg::MS_P10: begin
                w_a = 32'(r_lv2[45:32]);
                w_b = r_g2[31:0];
            end
            tobf_pkg::MS_P11: begin
                w_a = 32'(r_lv2[45:32]);
                w_b = r_g2[63:32];
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_item.mode;
            r_mag_td  <= tobf_pkg::f_mag(i_item.range_diff);
            r_mag_dx  <= tobf_pkg::f_mag_diff(i_item.anchor_a_x, i_item.anchor_b_x);
            r_mag_dy  <= tobf_pkg::f_mag_diff(i_item.anchor_a_y, i_item.anchor_b_y);
            r_mag_dz  <= tobf_pkg::f_mag_diff(i_item.anchor_a_z, i_item.anchor_b_z);
            r_mag_err <= tobf_pkg::f_mag(i_item.innovation);
            r_mag_gx  <= tobf_pkg::f_mag(i_item.grad_x);
            r_mag_gy  <= tobf_pkg::f_mag(i_item.grad_y);
            r_mag_gz  <= tobf_pkg::f_mag(i_item.grad_z);
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
            r_psel <= i_cmd.mul_sel;
        end
        // registered product is accumulated in the cycle after issue
        if (r_pv) begin
            case (r_psel)
                tobf_pkg::MS_TD:  r_td2     <= r_prod[62:0];
                tobf_pkg::MS_DX:  r_geo_sum <= {2'b00, r_prod};
                tobf_pkg::MS_DY:  r_geo_sum <= r_geo_sum + {2'b00, r_prod};
                tobf_pkg::MS_DZ:  r_geo_sum <= r_geo_sum + {2'b00, r_prod};
                tobf_pkg::MS_ERR: r_err2    <= r_prod[62:0];
                tobf_pkg::MS_GX:  r_g2      <= r_prod;
                tobf_pkg::MS_GY:  r_g2      <= r_g2 + r_prod;
                tobf_pkg::MS_GZ:  r_g2      <= r_g2 + r_prod;
                tobf_pkg::MS_LVL: r_lv2     <= r_prod[45:0];
                tobf_pkg::MS_P00: r_acc     <= {46'd0, r_prod};
                tobf_pkg::MS_P01: r_acc     <= r_acc + {14'd0, r_prod, 32'd0};
                tobf_pkg::MS_P10: r_acc     <= r_acc + {14'd0, r_prod, 32'd0};
                tobf_pkg::MS_P11: r_acc     <= r_acc + {r_prod[45:0], 64'd0};
                default: begin
                end
            endcase
        end
        if (i_cmd.upd_bucket) begin
            for (int i = 0; i < tobf_pkg::NUM_LEVELS; i++) begin
                if (i_cmd.lvl == tobf_pkg::LVL_IDX_W'(i)) begin
                    r_within[i] <= w_within;
                end
            end
        end
    end

    // td^2 < |a - b|^2, sum kept at full width so it never wraps
    assign w_geo_ok = {3'b000, r_td2} < r_geo_sum;

    // err^2 * 2^32 < level^2 * |grad|^2; zero gradient never passes
    assign w_within = {15'd0, r_err2, 32'd0} < r_acc;

    assign w_bkt_cur = r_bucket[i_cmd.lvl];

    always_comb begin
        n_bkt = w_bkt_cur;
        if (w_within) begin
            if (w_bkt_cur != '0) begin
                n_bkt = w_bkt_cur - 4'd1;
            end
        end else if (w_bkt_cur < tobf_pkg::BUCKET_MAX) begin
            n_bkt = w_bkt_cur + 4'd1;
        end
    end

    // lowest level under threshold, then hold-off before tightening
    always_comb begin
        w_idx = tobf_pkg::LEVEL_OPEN;
        for (int i = tobf_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_bucket[i] < tobf_pkg::BUCKET_THRESHOLD) begin
                w_idx = tobf_pkg::LVL_IDX_W'(i);
            end
        end
        w_sel  = w_idx;
        n_hold = r_hold;
        if (w_idx > r_prior) begin
            n_hold = r_close;
        end else if (w_idx < r_prior && r_hold != '0) begin
            n_hold = r_hold - 8'd1;
            w_sel  = r_prior;
        end
    end

    // open level always accepts
    assign w_within8 = {1'b1, r_within};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tobf_pkg::NUM_LEVELS; i++) begin
                r_bucket[i] <= '0;
            end
            r_prior <= '0;
            r_hold  <= '0;
        end else begin
            if (i_cmd.upd_bucket) begin
                for (int i = 0; i < tobf_pkg::NUM_LEVELS; i++) begin
                    if (i_cmd.lvl == tobf_pkg::LVL_IDX_W'(i)) begin
                        r_bucket[i] <= n_bkt;
                    end
                end
            end
            if (i_cmd.decide && r_mode && w_geo_ok) begin
                r_prior <= w_sel;
                r_hold  <= n_hold;
            end
        end
    end

    assign o_stat.mode   = r_mode;
    assign o_stat.geo_ok = w_geo_ok;

    assign o_res.accepted     = r_mode ? (w_geo_ok && w_within8[w_sel]) : w_geo_ok;
    assign o_res.active_level = (r_mode && w_geo_ok) ? w_sel : tobf_pkg::LEVEL_OPEN;

endmodule

`default_nettype wire

// File: test/tdoa_outlier_bucket_filter_tb.sv
// Self-checking testbench for tdoa_outlier_bucket_filter: directed and random
// stream traffic with an in-order verdict predictor in a small scoreboard class.
// Depends on tobf_pkg and the tdoa_outlier_bucket_filter RTL.
`timescale 1ns / 1ps

module tdoa_outlier_bucket_filter_tb;
    import tobf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ONE         = 65536;            // 1.0 in Q16.16
    localparam int S_MAX       = 32'sh7fff_ffff;
    localparam int S_MIN       = 32'sh8000_0000;
    localparam int PHASE_ITEMS = 225;
    localparam int CALM_PHASE  = 3;
    localparam logic [3:0] FILL_MAX    = 4'd10;
    localparam logic [3:0] FILL_THRESH = 4'd2;

    // Tracks filter state and holds the verdicts still owed by the block.
    class verdict_scoreboard;
        logic [NUM_LEVELS-1:0][LEVEL_W-1:0] level_cfg;
        logic [7:0]                         close_delay;
        logic [NUM_LEVELS-1:0][3:0]         fill;
        logic [2:0]                         prior_level;
        logic [7:0]                         hold_count;
        t_res                               verdict_q[$];
        int                                 n_checked;
        int                                 n_errors;

        function new();
            level_cfg[0] = 23'd26214;
            level_cfg[1] = 23'd52429;
            level_cfg[2] = 23'd78643;
            level_cfg[3] = 23'd104858;
            level_cfg[4] = 23'd131072;
            level_cfg[5] = 23'd196608;
            level_cfg[6] = 23'd262144;
            close_delay  = 8'd30;
            fill         = '0;
            prior_level  = '0;
            hold_count   = '0;
            n_checked    = 0;
            n_errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [LEVEL_W-1:0] val);
            if (idx == CFG_IDX_CLOSE)
                close_delay = val[7:0];
            else
                level_cfg[idx] = val;
        endfunction

        static function logic [63:0] mag_of(longint v);
            return (v < 0) ? 64'(-v) : 64'(v);
        endfunction

        // |err| < level * |grad|, squared and scaled so no division is needed
        static function bit within_level(logic [63:0] err2, logic [63:0] grad2,
                                         logic [LEVEL_W-1:0] lvl);
            logic [127:0] lhs;
            logic [127:0] rhs;
            lhs = 128'(err2) << 32;
            rhs = 128'(lvl) * 128'(lvl) * 128'(grad2);
            return lhs < rhs;
        endfunction

        function void note_sample(t_item it);
            logic [65:0] td;
            logic [65:0] dx;
            logic [65:0] dy;
            logic [65:0] dz;
            logic [63:0] e;
            logic [63:0] gx;
            logic [63:0] gy;
            logic [63:0] gz;
            logic [63:0] err2;
            logic [63:0] grad2;
            logic [2:0]  pick;
            bit          geo_ok;
            t_res        r;
            int          i;
            td = mag_of(longint'(signed'(it.range_diff)));
            dx = mag_of(longint'(signed'(it.anchor_a_x)) - longint'(signed'(it.anchor_b_x)));
            dy = mag_of(longint'(signed'(it.anchor_a_y)) - longint'(signed'(it.anchor_b_y)));
            dz = mag_of(longint'(signed'(it.anchor_a_z)) - longint'(signed'(it.anchor_b_z)));
            geo_ok = (td * td) < (dx * dx + dy * dy + dz * dz);
            r.accepted     = 1'b0;
            r.active_level = LEVEL_OPEN;
            if (!it.mode) begin
                r.accepted = geo_ok;
            end else if (geo_ok) begin
                e     = mag_of(longint'(signed'(it.innovation)));
                gx    = mag_of(longint'(signed'(it.grad_x)));
                gy    = mag_of(longint'(signed'(it.grad_y)));
                gz    = mag_of(longint'(signed'(it.grad_z)));
                err2  = e * e;
                grad2 = gx * gx + gy * gy + gz * gz;
                pick  = LEVEL_OPEN;
                for (i = NUM_LEVELS - 1; i >= 0; i--) begin
                    if (within_level(err2, grad2, level_cfg[i])) begin
                        if (fill[i] != 4'd0)
                            fill[i] = fill[i] - 4'd1;
                    end else if (fill[i] < FILL_MAX) begin
                        fill[i] = fill[i] + 4'd1;
                    end
                    if (fill[i] < FILL_THRESH)
                        pick = 3'(i);
                end
                // loosening is immediate, tightening waits out the hold counter
                if (pick > prior_level) begin
                    hold_count = close_delay;
                end else if (pick < prior_level && hold_count != 8'd0) begin
                    hold_count = hold_count - 8'd1;
                    pick = prior_level;
                end
                prior_level    = pick;
                r.active_level = pick;
                r.accepted     = (pick == LEVEL_OPEN) ? 1'b1
                                 : within_level(err2, grad2, level_cfg[pick]);
            end
            verdict_q.push_back(r);
        endfunction

        function void check_verdict(logic [OUT_TDATA_W-1:0] tdata);
            t_res want;
            n_checked++;
            if (verdict_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("mismatch #%0d: verdict %h with nothing pending", n_errors, tdata);
                return;
            end
            want = verdict_q.pop_front();
            if (tdata[0] !== want.accepted || tdata[3:1] !== want.active_level ||
                tdata[7:4] !== 4'd0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("mismatch #%0d at verdict %0d: expected accepted=%0b level=%0d, got accepted=%0b level=%0d pad=%h",
                             n_errors, n_checked, want.accepted, want.active_level,
                             tdata[0], tdata[3:1], tdata[7:4]);
            end
        endfunction

        function void close_out();
            if (verdict_q.size() != 0) begin
                n_errors += verdict_q.size();
                $display("%0d verdicts never arrived", verdict_q.size());
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] range_diff, anchor_a x/y/z, anchor_b x/y/z, innovation, grad x/y/z
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [0] mode
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] accepted, [3:1] active_level, [7:4] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [LEVEL_W-1:0]     i_cfg_wdata   = '0;

    verdict_scoreboard sb;
    int  cycles    = 0;
    int  hold_left = 0;
    bit  held      = 1'b0;
    bit  calm      = 1'b0;

    tdoa_outlier_bucket_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tdoa_outlier_bucket_filter_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_verdict(m_axis_tdata);
    end

    // Result side: random stalls, plus one long hold-off to back the block up.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!held && sb.n_checked >= 300) begin
            held = 1'b1;
            hold_left = 600;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    function automatic t_item sample_of(bit m, int rd, int ax, int ay, int az,
                                        int bx, int by, int bz, int inn,
                                        int gx, int gy, int gz);
        t_item it;
        it.mode       = m;
        it.range_diff = rd;
        it.anchor_a_x = ax;
        it.anchor_a_y = ay;
        it.anchor_a_z = az;
        it.anchor_b_x = bx;
        it.anchor_b_y = by;
        it.anchor_b_z = bz;
        it.innovation = inn;
        it.grad_x     = gx;
        it.grad_y     = gy;
        it.grad_z     = gz;
        return it;
    endfunction

    function automatic t_item noise_sample();
        return sample_of($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
    endfunction

    // Plausible stepped sample: anchors well apart, gradient near one axis, and an
    // error scaled around acceptance level k (k = 7 means far beyond every level).
    function automatic t_item well_formed(int k, bit break_geo, bit zero_grad);
        int     a [3];
        int     off [3];
        int     g [3];
        int     axis;
        int     span;
        int     rd;
        int     gmag;
        longint err;
        for (int j = 0; j < 3; j++) begin
            a[j]   = int'($urandom) >>> 3;
            off[j] = $urandom_range(0, 8191) - 4096;
            g[j]   = $urandom_range(0, 511) - 256;
        end
        axis      = $urandom_range(0, 2);
        span      = $urandom_range(1 << 16, 1 << 24);
        off[axis] = $urandom_range(0, 1) ? span : -span;
        rd        = break_geo ? 2 * span + $urandom_range(0, 1 << 16)
                              : $urandom_range(0, span - 1);
        if ($urandom_range(0, 1))
            rd = -rd;
        axis    = $urandom_range(0, 2);
        gmag    = $urandom_range(1 << 14, 1 << 18);
        g[axis] = $urandom_range(0, 1) ? gmag : -gmag;
        if (zero_grad)
            g = '{0, 0, 0};
        if (k >= NUM_LEVELS)
            err = $urandom_range(1 << 26, 1 << 30);
        else
            err = (longint'(sb.level_cfg[k]) * gmag * $urandom_range(0, 2048)) >> 26;
        if ($urandom_range(0, 1))
            err = -err;
        return sample_of(1'b1, rd, a[0], a[1], a[2], a[0] + off[0], a[1] + off[1],
                         a[2] + off[2], int'(err), g[0], g[1], g[2]);
    endfunction

    task automatic send_sample(t_item it);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {it.grad_z, it.grad_y, it.grad_x, it.innovation,
                          it.anchor_b_z, it.anchor_b_y, it.anchor_b_x,
                          it.anchor_a_z, it.anchor_a_y, it.anchor_a_x, it.range_diff};
        s_axis_tuser  <= it.mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(it);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [LEVEL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_phase(int p);
        logic [LEVEL_W-1:0] v [8];
        logic [LEVEL_W-1:0] acc;
        int                 i;
        case (p)
            1: begin
                acc = '0;
                for (i = 0; i < NUM_LEVELS; i++) begin
                    acc  = acc + 23'($urandom_range(0, 900000));
                    v[i] = acc;
                end
                v[7] = 23'd0;
            end
            2: begin
                v[0] = 23'd0;
                for (i = 1; i < NUM_LEVELS - 1; i++)
                    v[i] = 23'(i * 1000000);
                v[6] = 23'd6553600;
                v[7] = 23'd255;
            end
            3: begin
                for (i = 0; i < NUM_LEVELS; i++)
                    v[i] = 23'($urandom_range(0, 6553600));
                v[7] = 23'($urandom);          // bits above the delay field too
            end
            4: begin
                for (i = 0; i < NUM_LEVELS; i++)
                    v[i] = 23'd6553600;
                v[7] = 23'd3;
            end
            default: begin
                for (i = 0; i < 4; i++)
                    v[i] = 23'd0;
                v[4] = 23'd131072;
                v[5] = 23'd196608;
                v[6] = 23'd262144;
                v[7] = 23'd1;
            end
        endcase
        for (i = 0; i < 8; i++)
            write_cfg(3'(i), v[i]);
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic run_directed();
        // simple mode: coincident anchors, unit baseline, widest baseline,
        // range exactly equal to baseline, squared sums past 64 bits
        send_sample(sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(sample_of(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        send_sample(sample_of(0, S_MIN, S_MIN, 0, 0, S_MAX, 0, 0, 0, 0, 0, 0));
        send_sample(sample_of(0, 5 * ONE, 0, 0, 0, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0));
        send_sample(sample_of(0, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX,
                              S_MAX, S_MAX, S_MAX, S_MAX));
        send_sample(sample_of(0, -1, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN,
                              S_MIN, S_MIN, S_MIN, S_MIN));
        // stepped mode, geometry rejected
        send_sample(sample_of(1, 10 * ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0));
        send_sample(sample_of(1, -1, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0));
        // zero gradient twice: every bucket fills until the filter opens
        send_sample(sample_of(1, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
        send_sample(sample_of(1, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
        // error right on the tightest level, then just inside it
        send_sample(sample_of(1, 0, 0, 0, 0, ONE, 0, 0, 26214, ONE, 0, 0));
        send_sample(sample_of(1, 0, 0, 0, 0, ONE, 0, 0, -26213, -ONE, 0, 0));
        send_sample(sample_of(1, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 1));
        // extreme error and gradient magnitudes
        send_sample(sample_of(1, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX,
                              S_MIN, S_MIN, S_MIN, S_MIN));
        send_sample(sample_of(1, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN,
                              S_MAX, S_MAX, S_MAX, S_MAX));
        send_sample(sample_of(1, 0, 0, 0, 0, 0, 0, ONE, S_MAX, 1, 0, 0));
        send_sample(sample_of(1, 0, 0, 0, 0, 0, ONE, 0, 0, S_MIN, S_MAX, 0));
    endtask

    task automatic run_random(int count);
        t_item it;
        int    left;
        int    r;
        int    k;
        int    len;
        int    j;
        left = count;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                // run of stepped samples around one level so buckets settle
                k   = $urandom_range(0, NUM_LEVELS);
                len = $urandom_range(3, 40);
                for (j = 0; j < len && left > 0; j++) begin
                    r = $urandom_range(0, 99);
                    send_sample(well_formed(k, r < 4, r >= 4 && r < 8));
                    left--;
                end
            end else if (r < 90) begin
                it = well_formed(0, $urandom_range(0, 1), 1'b0);
                it.mode = 1'b0;
                send_sample(it);
                left--;
            end else begin
                send_sample(noise_sample());
                left--;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_ITEMS);
        wait_drained();
        for (int p = 1; p <= 5; p++) begin
            calm = (p == CALM_PHASE);
            program_phase(p);
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (80) @(posedge i_clk);
        sb.close_out();
        if (sb.n_errors == 0)
            $display("tdoa_outlier_bucket_filter_tb: PASS");
        else
            $display("tdoa_outlier_bucket_filter_tb: FAIL");
        $finish;
    end

endmodule
